// File: rtl/core/aslq_pkg.sv
// ---------------------------------------------------------------------------
// aslq_pkg
// Shared types, constants and the square-root step of the line quantizer.
// ---------------------------------------------------------------------------
package aslq_pkg;

    localparam int SQ1_STEPS = 28;                       // sqrt(|x| << 24)
    localparam int SQ2_STEPS = 22;                       // sqrt(s1 << 16)
    localparam int SQ_STAGES = SQ1_STEPS + SQ2_STEPS;

    localparam logic [36:0] ROUND_OFFSET_Q38 = 37'd111435503475;
    localparam logic [15:0] POS_LIMIT        = 16'd32767;
    localparam logic [15:0] NEG_LIMIT        = 16'd32768;
    localparam logic [5:0]  FRAC_SHIFT       = 6'd38;

    // 2^(r/16) in Q30
    localparam logic [30:0] STEP_FRAC_Q30 [16] = '{
        31'd1073741824, 31'd1121280436, 31'd1170923762, 31'd1222764986,
        31'd1276901417, 31'd1333434672, 31'd1392470869, 31'd1454120821,
        31'd1518500250, 31'd1585730000, 31'd1655936265, 31'd1729250827,
        31'd1805811301, 31'd1885761398, 31'd1969251188, 31'd2056437387
    };

    typedef struct packed {
        logic              neg;
        logic              last;
        logic [3:0]        frac;     // r of the step split
        logic signed [5:0] expo;     // n of the step split
        logic [27:0]       s1;       // first root, held for the product
        logic [55:0]       rad;      // radicand, consumed two bits a stage
        logic [29:0]       rem;
        logic [27:0]       root;
    } sq_t;

    // One restoring square-root step: one result bit.
    function automatic sq_t sqrt_step(input sq_t s);
        sq_t         o;
        logic [31:0] acc;
        logic [31:0] trial;
        logic [31:0] diff;
        o     = s;
        acc   = {s.rem, s.rad[55:54]};
        trial = {2'b00, s.root, 2'b01};
        diff  = acc - trial;
        if (acc >= trial)
        begin
            o.rem  = diff[29:0];
            o.root = {s.root[26:0], 1'b1};
        end
        else
        begin
            o.rem  = acc[29:0];
            o.root = {s.root[26:0], 1'b0};
        end
        o.rad = {s.rad[53:0], 2'b00};
        return o;
    endfunction

endpackage

// File: rtl/core/aslq_if.sv
// ---------------------------------------------------------------------------
// aslq_in_if / aslq_out_if
// Valid/ready channels carrying spectral lines in and quantized words out.
// ---------------------------------------------------------------------------
interface aslq_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] spectral_value;
    logic signed [7:0]  scale_gain;
    logic              last_line;

    modport source (output valid, output spectral_value, output scale_gain,
                    output last_line, input ready);
    modport sink   (input valid, input spectral_value, input scale_gain,
                    input last_line, output ready);
endinterface

interface aslq_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] quant_value;
    logic [31:0]        power_magnitude;
    logic              last_out;

    modport source (output valid, output quant_value, output power_magnitude,
                    output last_out, input ready);
    modport sink   (input valid, input quant_value, input power_magnitude,
                    input last_out, output ready);
endinterface

// File: rtl/core/aac_spectral_line_quantizer.sv
// ---------------------------------------------------------------------------
// aac_spectral_line_quantizer
// Nonuniform |x|^0.75 quantizer for one MDCT line per word.
// ---------------------------------------------------------------------------
// Usage:
//  line_in   : one word per spectral line: Q23.8 coefficient, band gain,
//              last-line mark. Taken when valid and ready are both high.
//  quant_out : quantized line (saturated to 16 bits signed), |x|^0.75 in
//              Q24.8 and the copied last-line mark, one word per line.
//  Throughput: one word per cycle while quant_out is not stalled. Lines are
//              independent, so the pipeline never waits on a previous line.
//  Path      : from acceptance to quant_out.valid a line passes the input
//              register, the two bit-per-stage square roots (28 + 22
//              stages), product, step multiply, round/align stage and the
//              output register.
//  Stall     : the whole pipeline holds when quant_out is stalled with a
//              word waiting; line_in.ready drops in the same cycle, no word
//              is lost or repeated. Bubbles are not squeezed out.
//  Reset     : rst_n clears every stage valid bit; tail data is not reset.
// ---------------------------------------------------------------------------
module aac_spectral_line_quantizer (
    input  logic              clk,
    input  logic              rst_n,
    aslq_in_if.sink           line_in,
    aslq_out_if.source        quant_out
);
    import aslq_pkg::*;

    // global advance: output register free or being drained
    logic adv;

    // input register and square-root stages (index 0 is the input register)
    logic        vld_reg  [SQ_STAGES+1];
    sq_t         sq_reg   [SQ_STAGES+1];
    sq_t         sq_next  [SQ_STAGES+1];

    // tail stages
    logic        t1_vld_reg, t2_vld_reg, t3_vld_reg;
    logic        t1_neg_reg, t2_neg_reg, t3_neg_reg;
    logic        t1_last_reg, t2_last_reg, t3_last_reg;
    logic [3:0]  t1_frac_reg;
    logic signed [5:0] t1_expo_reg, t2_expo_reg;
    logic [49:0] t1_prod_reg;
    logic [25:0] t2_pw_reg, t3_pw_reg;
    logic [56:0] t2_m_reg;
    logic [63:0] t3_num_reg;
    logic [5:0]  t3_sht_reg;
    logic        t3_ovf_reg;

    // output register
    logic              out_vld_reg;
    logic signed [15:0] out_q_reg;
    logic [31:0]        out_pw_reg;
    logic              out_last_reg;

    assign adv           = !out_vld_reg || quant_out.ready;
    assign line_in.ready = adv;

    // -----------------------------------------------------------------------
    // input stage: magnitude and floor split of -3g = 16n + r
    // -----------------------------------------------------------------------
    logic signed [10:0] biased;
    logic signed [6:0]  expo_w;
    logic [31:0]        mag;
    sq_t                in_next;

    always_comb
    begin
        biased = 11'sd384 - 11'sd3 * 11'(line_in.scale_gain);
        expo_w = $signed({1'b0, biased[9:4]}) - 7'sd24;
        mag    = line_in.spectral_value[31] ? (32'd0 - line_in.spectral_value)
                                            : line_in.spectral_value;
        in_next      = '0;
        in_next.neg  = line_in.spectral_value[31];
        in_next.last = line_in.last_line;
        in_next.frac = biased[3:0];
        in_next.expo = expo_w[5:0];
        in_next.rad  = {mag[31:0], 24'd0};
    end

    // -----------------------------------------------------------------------
    // square-root stages; the second root restarts after the first finishes
    // -----------------------------------------------------------------------
    always_comb
    begin
        sq_t src;
        sq_next[0] = in_next;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            src = sq_reg[k];
            if (k == SQ1_STEPS)
            begin
                src.s1   = sq_reg[k].root;
                src.rad  = {sq_reg[k].root, 28'd0};   // s1 << 16, left aligned
                src.rem  = '0;
                src.root = '0;
            end
            sq_next[k+1] = sqrt_step(src);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
                sq_reg[k]  <= '0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= line_in.valid;
            sq_reg[0]  <= sq_next[0];
            for (int k = 1; k <= SQ_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
                sq_reg[k]  <= sq_next[k];
            end
        end
    end

    // -----------------------------------------------------------------------
    // tail: product, step multiply, round/align, shift and saturate
    // -----------------------------------------------------------------------
    logic [63:0] num_w;
    logic [5:0]  sht_w;
    logic        ovf_w;
    logic [4:0]  sh_pos, sh_neg;
    logic [63:0] m_ext;
    logic [63:0] ival;
    logic [15:0] qmag;

    always_comb
    begin
        m_ext  = {7'd0, t2_m_reg};
        sh_pos = t2_expo_reg[4:0];
        sh_neg = 5'(6'd0 - t2_expo_reg);
        if (!t2_expo_reg[5])
        begin
            ovf_w = (m_ext >> (6'd53 - {1'b0, sh_pos})) != '0;
            num_w = (m_ext << sh_pos) + {27'd0, ROUND_OFFSET_Q38};
            sht_w = FRAC_SHIFT;
        end
        else
        begin
            ovf_w = 1'b0;
            num_w = m_ext + ({27'd0, ROUND_OFFSET_Q38} << sh_neg);
            sht_w = FRAC_SHIFT + {1'b0, sh_neg};
        end
    end

    always_comb
    begin
        ival = t3_num_reg >> t3_sht_reg;
        if (t3_neg_reg)
            qmag = (t3_ovf_reg || ival > {48'd0, NEG_LIMIT}) ? NEG_LIMIT : ival[15:0];
        else
            qmag = (t3_ovf_reg || ival > {48'd0, POS_LIMIT}) ? POS_LIMIT : ival[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            t3_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            t1_vld_reg  <= vld_reg[SQ_STAGES];
            t2_vld_reg  <= t1_vld_reg;
            t3_vld_reg  <= t2_vld_reg;
            out_vld_reg <= t3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_neg_reg  <= sq_reg[SQ_STAGES].neg;
            t1_last_reg <= sq_reg[SQ_STAGES].last;
            t1_frac_reg <= sq_reg[SQ_STAGES].frac;
            t1_expo_reg <= sq_reg[SQ_STAGES].expo;
            t1_prod_reg <= sq_reg[SQ_STAGES].s1 * sq_reg[SQ_STAGES].root[21:0];

            t2_neg_reg  <= t1_neg_reg;
            t2_last_reg <= t1_last_reg;
            t2_expo_reg <= t1_expo_reg;
            t2_pw_reg   <= t1_prod_reg[49:24];
            t2_m_reg    <= t1_prod_reg[49:24] * STEP_FRAC_Q30[t1_frac_reg];

            t3_neg_reg  <= t2_neg_reg;
            t3_last_reg <= t2_last_reg;
            t3_pw_reg   <= t2_pw_reg;
            t3_num_reg  <= num_w;
            t3_sht_reg  <= sht_w;
            t3_ovf_reg  <= ovf_w;

            out_q_reg    <= t3_neg_reg ? $signed(16'd0 - qmag) : $signed(qmag);
            out_pw_reg   <= {6'd0, t3_pw_reg};
            out_last_reg <= t3_last_reg;
        end
    end

    assign quant_out.valid           = out_vld_reg;
    assign quant_out.quant_value     = out_q_reg;
    assign quant_out.power_magnitude = out_pw_reg;
    assign quant_out.last_out        = out_last_reg;

`ifndef ASSERT_OFF
    // remainder bound of the first root
    a_sq1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ1_STEPS] |-> ({1'b0, sq_reg[SQ1_STEPS].rem} <=
                                {2'b00, sq_reg[SQ1_STEPS].root, 1'b0}))
        else $error("first root remainder out of range");

    // remainder bound of the second root
    a_sq2_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQ_STAGES] |-> ({1'b0, sq_reg[SQ_STAGES].rem} <=
                                {2'b00, sq_reg[SQ_STAGES].root, 1'b0}))
        else $error("second root remainder out of range");

    // zero power gives a zero line
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_pw_reg == '0) |-> (out_q_reg == '0))
        else $error("nonzero line from zero power");

    // a negative line needs a nonzero magnitude
    a_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_q_reg[15]) |-> (out_pw_reg != '0))
        else $error("negative line from zero power");
`endif

endmodule

// File: dv/tb_aac_spectral_line_quantizer.sv
// ---------------------------------------------------------------------------
// tb_aac_spectral_line_quantizer
// Self-checking bench for the |x|^0.75 spectral line quantizer.
// Every accepted line is predicted bit for bit and queued. Each output word
// is checked against the oldest prediction. Over three phases: a slow
// receiver, then a slow sender, both stalling at random, then full rate.
// ---------------------------------------------------------------------------
module tb_aac_spectral_line_quantizer;
    import aslq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_PER_PHASE = 477;

    typedef struct {
        logic signed [31:0] value;
        logic signed [7:0]  gain;
        logic               last;
    } line_t;

    typedef struct {
        logic signed [15:0] quant;
        logic [31:0]        power;
        logic               last;
    } quant_word_t;

    logic clk;
    logic rst_n;

    aslq_in_if  line_in ();
    aslq_out_if quant_out ();

    aac_spectral_line_quantizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .quant_out (quant_out)
    );

    line_t       line_queue[$];      // lines waiting to be driven
    quant_word_t quant_expected[$];  // predicted words, oldest first
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          cycles;

    // Floor square root, one result bit per pass.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bit_w;
        root  = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= root + bit_w)
            begin
                v    = v - (root + bit_w);
                root = (root >> 1) + bit_w;
            end
            else
                root = root >> 1;
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // Quantized word for one line.
    function automatic quant_word_t quantize_line(line_t ln);
        quant_word_t     w;
        longint unsigned mag;
        longint unsigned s1;
        longint unsigned s2;
        longint unsigned pw;
        longint unsigned m;
        longint unsigned num;
        longint unsigned ival;
        int              biased;
        int              n;
        int              r;
        mag = ln.value[31] ? (64'h1_0000_0000 - {32'd0, ln.value}) : {32'd0, ln.value};
        s1  = floor_sqrt(mag << 24);
        s2  = floor_sqrt(s1 << 16);
        pw  = (s1 * s2) >> 24;
        if (pw > 64'hFFFF_FFFF)
            pw = 64'hFFFF_FFFF;
        // floor split of -3g into 16n + r
        biased = 384 - 3 * int'(ln.gain);
        n      = (biased >> 4) - 24;
        r      = biased & 15;
        m      = pw * longint'(STEP_FRAC_Q30[r]);
        if (n >= 0)
        begin
            if ((m >> (53 - n)) != 0)
                ival = 64'd32769;
            else
            begin
                num  = (m << n) + longint'(ROUND_OFFSET_Q38);
                ival = num >> 38;
            end
        end
        else
        begin
            num  = m + (longint'(ROUND_OFFSET_Q38) << (-n));
            ival = num >> (38 - n);
        end
        if (ln.value[31])
        begin
            if (ival > 64'd32768)
                ival = 64'd32768;
            w.quant = 16'(64'h1_0000 - ival);
        end
        else
        begin
            if (ival > 64'd32767)
                ival = 64'd32767;
            w.quant = 16'(ival);
        end
        w.power = pw[31:0];
        w.last  = ln.last;
        return w;
    endfunction

    function automatic line_t make_line(logic signed [31:0] v, logic signed [7:0] g,
                                        logic l);
        line_t ln;
        ln.value = v;
        ln.gain  = g;
        ln.last  = l;
        return ln;
    endfunction

    // Random line: magnitudes spread over all scales, gains biased to where
    // the quantized value is neither zero nor saturated.
    function automatic line_t random_line();
        line_t       ln;
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(3) == 0)
            ln.value = raw;
        else
            ln.value = $signed(raw) >>> $urandom_range(31);
        if ($urandom_range(2) == 0)
            ln.gain = 8'($urandom);
        else
            ln.gain = 8'($urandom_range(90)) - 8'sd40;
        ln.last = $urandom_range(7) == 0;
        return ln;
    endfunction

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Driver: next line once the current word has gone or the slot is empty.
    always @(posedge clk or negedge rst_n)
    begin
        line_t ln;
        if (!rst_n)
            line_in.valid <= 1'b0;
        else
        begin
            if (line_in.valid && line_in.ready)
                quant_expected.push_back(quantize_line(make_line(line_in.spectral_value,
                    line_in.scale_gain, line_in.last_line)));
            if (!line_in.valid || line_in.ready)
            begin
                if (line_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ln = line_queue.pop_front();
                    line_in.spectral_value <= ln.value;
                    line_in.scale_gain     <= ln.gain;
                    line_in.last_line      <= ln.last;
                    line_in.valid          <= 1'b1;
                end
                else
                    line_in.valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
        quant_out.ready <= $urandom_range(99) >= recv_idle_pct;

    // Monitor: compare each taken word with the oldest prediction.
    always @(posedge clk)
    begin
        quant_word_t w;
        if (rst_n && quant_out.valid && quant_out.ready)
        begin
            if (quant_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: quant %0d power %0h last %0b",
                             quant_out.quant_value, quant_out.power_magnitude,
                             quant_out.last_out);
            end
            else
            begin
                w = quant_expected.pop_front();
                if (quant_out.quant_value !== w.quant
                    || quant_out.power_magnitude !== w.power
                    || quant_out.last_out !== w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: quant %0d/%0d power %0h/%0h last %0b/%0b (exp/act)",
                                 w.quant, quant_out.quant_value, w.power,
                                 quant_out.power_magnitude, w.last, quant_out.last_out);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int phase;
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cycles                 = 0;
        mismatches             = 0;
        line_in.valid          = 1'b0;
        line_in.spectral_value = '0;
        line_in.scale_gain     = '0;
        line_in.last_line      = 1'b0;
        quant_out.ready        = 1'b0;
        send_idle_pct          = 7;
        recv_idle_pct          = 86;

        // directed: zero, extremes of value and gain, saturation both ways
        line_queue.push_back(make_line(32'sd0, 8'sd0, 1'b0));
        line_queue.push_back(make_line(32'sd0, -8'sd128, 1'b1));
        line_queue.push_back(make_line(32'sd1, 8'sd0, 1'b0));
        line_queue.push_back(make_line(-32'sd1, 8'sd0, 1'b0));
        line_queue.push_back(make_line(32'sd256, 8'sd0, 1'b0));
        line_queue.push_back(make_line(-32'sd256, 8'sd0, 1'b1));
        line_queue.push_back(make_line(32'h7FFF_FFFF, 8'sd127, 1'b0));
        line_queue.push_back(make_line(32'h7FFF_FFFF, -8'sd128, 1'b0));
        line_queue.push_back(make_line(32'h7FFF_FFFF, 8'sd0, 1'b0));
        line_queue.push_back(make_line(32'h8000_0000, 8'sd0, 1'b0));
        line_queue.push_back(make_line(32'h8000_0000, -8'sd128, 1'b1));
        line_queue.push_back(make_line(32'h8000_0000, 8'sd127, 1'b0));
        line_queue.push_back(make_line(32'h8000_0001, 8'sd0, 1'b0));
        line_queue.push_back(make_line(32'sd1, -8'sd128, 1'b0));
        line_queue.push_back(make_line(-32'sd1, -8'sd128, 1'b0));
        line_queue.push_back(make_line(32'sd1000000, 8'sd40, 1'b0));
        line_queue.push_back(make_line(-32'sd1000000, 8'sd40, 1'b0));
        line_queue.push_back(make_line(32'sd1000000, -8'sd10, 1'b0));
        line_queue.push_back(make_line(-32'sd1000000, -8'sd10, 1'b1));
        line_queue.push_back(make_line(32'sd65536, 8'sd5, 1'b0));
        line_queue.push_back(make_line(-32'sd65536, 8'sd6, 1'b0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 7;
            end
            else if (phase == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            repeat (RAND_PER_PHASE) line_queue.push_back(random_line());
            wait (line_queue.size() == 0);
        end

        // drain
        @(posedge clk);
        while (line_in.valid || quant_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && quant_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
